@@ sv/tlv_pkg.sv @@
// ----------------------------------------------------------------------------
// TLV tag extractor package
// Shared widths, register indexes, parser phases, status codes and the
// length-width lookup used by the extractor and its channel interfaces.
// ----------------------------------------------------------------------------
package tlv_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ObjIdW  = 24;
  localparam int unsigned LenW    = 16;
  localparam int unsigned LenCntW = 2;
  localparam int unsigned StatusW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_OBJECT_ID   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_TAG  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CAPACITY    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LENGTH_ONLY = 2'd3;

  // Data objects and tags whose elements carry a two-byte length.
  localparam logic [ObjIdW-1:0] OBJ_FACIAL_IMAGE = 24'h5FC102;
  localparam logic [ObjIdW-1:0] OBJ_FINGERPRINT  = 24'hDFC103;
  localparam logic [ObjIdW-1:0] OBJ_SECURITY     = 24'hDFC10F;
  localparam logic [ByteW-1:0]  TAG_FACIAL_IMAGE = 8'h3E;
  localparam logic [ByteW-1:0]  TAG_FINGERPRINT  = 8'hBC;
  localparam logic [ByteW-1:0]  TAG_SECURITY     = 8'hBB;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN,
    PH_SKIP,
    PH_STREAM,
    PH_DONE
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_FOUND,
    ST_NOT_FOUND,
    ST_OVER_CAP,
    ST_TRUNCATED
  } status_e;

  // Number of length bytes per element for the selected object and tag.
  function automatic logic [LenCntW-1:0] length_width(input logic [ObjIdW-1:0] obj,
                                                      input logic [ByteW-1:0]  tag);
    logic [LenCntW-1:0] w;
    w = 2'd1;
    if ((obj == OBJ_FACIAL_IMAGE && tag == TAG_FACIAL_IMAGE) ||
        (obj == OBJ_FINGERPRINT  && tag == TAG_FINGERPRINT)  ||
        (obj == OBJ_SECURITY     && tag == TAG_SECURITY)) begin
      w = 2'd2;
    end
    return w;
  endfunction

endpackage

@@ sv/tlv_in_if.sv @@
// ----------------------------------------------------------------------------
// TLV record byte channel
// Valid/ready channel carrying one record byte and its end-of-record flag.
// ----------------------------------------------------------------------------
interface tlv_in_if;
  import tlv_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

@@ sv/tlv_out_if.sv @@
// ----------------------------------------------------------------------------
// TLV result channel
// Valid/ready channel carrying value bytes, search status and tag length.
// ----------------------------------------------------------------------------
interface tlv_out_if;
  import tlv_pkg::*;

  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   value_byte;
  logic               value_valid;
  logic               status_valid;
  logic [StatusW-1:0] status;
  logic [LenW-1:0]    tag_length;

  modport source (output valid, output value_byte, output value_valid,
                  output status_valid, output status, output tag_length,
                  input ready);
  modport sink   (input valid, input value_byte, input value_valid,
                  input status_valid, input status, input tag_length,
                  output ready);

endinterface

@@ sv/tlv_tag_value_extractor.sv @@
// ----------------------------------------------------------------------------
// TLV tag value extractor
// Parses a tag-length-value record one byte per transaction and returns the
// value or the length of the first element whose tag matches target_tag.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  --------  ---  -------------  ----------------------------------------------
//  in_i      in   valid/ready    data_byte, last_byte
//  out_o     out  valid/ready    value_byte, value_valid, status_valid,
//                                status, tag_length
//  cfg       in   cfg_we_i only  cfg_idx_i, cfg_data_i
//
//  One byte is accepted per cycle while the skid register is empty. The parser
//  state and the result are both computed from the accepted byte in the same
//  cycle; the result lands in a two-entry output buffer (output register plus
//  skid register) and is shown from the output register. The input is ready
//  whenever the skid register is empty, so a waiting result does not block the
//  next byte. Reset clears the parser, the configuration and the output buffer.
//
module tlv_tag_value_extractor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tlv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlv_pkg::CfgDataW-1:0] cfg_data_i,
  tlv_in_if.sink                       in_i,
  tlv_out_if.source                    out_o
);
  import tlv_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] value_byte;
    logic             value_valid;
    logic             status_valid;
    status_e          status;
    logic [LenW-1:0]  tag_length;
  } result_t;

  // Configuration registers.
  logic [ObjIdW-1:0] object_id_q;
  logic [ByteW-1:0]  target_tag_q;
  logic [LenW-1:0]   capacity_q;
  logic              length_only_q;

  // Parser state and its next values.
  phase_e             phase_q, phase_d;
  logic [LenCntW-1:0] len_left_q, len_left_d;
  logic               is_match_q, is_match_d;
  logic [LenW-1:0]    len_accum_q, len_accum_d;
  logic [LenW-1:0]    val_left_q, val_left_d;

  // State after the byte is parsed but before end-of-record rearming.
  phase_e             phase_s;
  logic [LenCntW-1:0] len_left_s;
  logic               is_match_s;
  logic [LenW-1:0]    len_accum_s;
  logic [LenW-1:0]    val_left_s;

  // Output buffer.
  result_t res;
  logic    has_res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  logic in_acc, out_pop, push;

  assign in_i.ready = ~skid_valid_q;
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_pop    = out_valid_q & out_o.ready;
  assign push       = in_acc & has_res;

  // --------------------------------------------------------------------------
  // Configuration writes. Indexes beyond the register list do not exist since
  // the index is exactly two bits wide.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      object_id_q   <= '0;
      target_tag_q  <= '0;
      capacity_q    <= '0;
      length_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OBJECT_ID:   object_id_q   <= cfg_data_i[ObjIdW-1:0];
        REG_TARGET_TAG:  target_tag_q  <= cfg_data_i[ByteW-1:0];
        REG_CAPACITY:    capacity_q    <= cfg_data_i[LenW-1:0];
        REG_LENGTH_ONLY: length_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Parse step: advance the parser by one record byte.
  // --------------------------------------------------------------------------
  always_comb begin
    phase_s     = phase_q;
    len_left_s  = len_left_q;
    is_match_s  = is_match_q;
    len_accum_s = len_accum_q;
    val_left_s  = val_left_q;
    case (phase_q)
      PH_TAG: begin
        is_match_s  = (in_i.data_byte == target_tag_q);
        len_accum_s = '0;
        len_left_s  = length_width(object_id_q, target_tag_q);
        phase_s     = PH_LEN;
      end
      PH_LEN: begin
        // Big-endian accumulation of the length bytes.
        len_accum_s = {len_accum_q[LenW-ByteW-1:0], in_i.data_byte};
        len_left_s  = (len_left_q == '0) ? '0 : len_left_q - 2'd1;
        if (len_left_s == '0) begin
          if (is_match_q) begin
            if (length_only_q || len_accum_s == '0 || len_accum_s > capacity_q) begin
              phase_s = PH_DONE;
            end else begin
              val_left_s = len_accum_s;
              phase_s    = PH_STREAM;
            end
          end else if (len_accum_s == '0) begin
            phase_s = PH_TAG;
          end else begin
            val_left_s = len_accum_s;
            phase_s    = PH_SKIP;
          end
        end
      end
      PH_SKIP, PH_STREAM: begin
        val_left_s = (val_left_q == '0) ? '0 : val_left_q - 16'd1;
        if (val_left_s == '0) begin
          phase_s = (phase_q == PH_SKIP) ? PH_TAG : PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // Next state: the final byte of a record always rearms the parser.
  always_comb begin
    if (in_i.last_byte) begin
      phase_d     = PH_TAG;
      len_left_d  = '0;
      is_match_d  = 1'b0;
      len_accum_d = '0;
      val_left_d  = '0;
    end else begin
      phase_d     = phase_s;
      len_left_d  = len_left_s;
      is_match_d  = is_match_s;
      len_accum_d = len_accum_s;
      val_left_d  = val_left_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      len_left_q  <= '0;
      is_match_q  <= 1'b0;
      len_accum_q <= '0;
      val_left_q  <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      len_left_q  <= len_left_d;
      is_match_q  <= is_match_d;
      len_accum_q <= len_accum_d;
      val_left_q  <= val_left_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result for the accepted byte. A byte yields a result when it is a value
  // byte of the matched element or when it ends the search.
  // --------------------------------------------------------------------------
  always_comb begin
    res = '{value_byte: '0, value_valid: 1'b0, status_valid: 1'b0,
            status: ST_FOUND, tag_length: '0};
    case (phase_q)
      PH_LEN: begin
        if (len_left_s == '0 && is_match_q) begin
          res.tag_length = len_accum_s;
          if (length_only_q || len_accum_s == '0) begin
            res.status_valid = 1'b1;
          end else if (len_accum_s > capacity_q) begin
            res.status_valid = 1'b1;
            res.status       = ST_OVER_CAP;
          end
        end
      end
      PH_STREAM: begin
        res.value_byte  = in_i.data_byte;
        res.value_valid = 1'b1;
        res.tag_length  = len_accum_q;
        if (val_left_s == '0) begin
          res.status_valid = 1'b1;
        end
      end
      default: ;
    endcase

    // The record ends before the search has finished.
    if (in_i.last_byte && !res.status_valid && phase_s != PH_DONE) begin
      res.status_valid = 1'b1;
      if (phase_s == PH_STREAM) begin
        res.status     = ST_TRUNCATED;
        res.tag_length = len_accum_s;
      end else if (phase_s == PH_LEN && is_match_s) begin
        res.status     = ST_TRUNCATED;
        res.tag_length = '0;
      end else begin
        res.status     = ST_NOT_FOUND;
        res.tag_length = '0;
      end
    end
  end

  assign has_res = res.value_valid | res.status_valid;

  // --------------------------------------------------------------------------
  // Output register with a skid register behind it. New results go to the
  // skid register only while the output register is full and stalled.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop) begin
      out_valid_q  <= skid_valid_q | push;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q) begin
      out_valid_q <= push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (push && (out_pop || !out_valid_q)) begin
      out_q <= res;
    end
    if (push && out_valid_q && !out_pop) begin
      skid_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.value_byte   = out_q.value_byte;
  assign out_o.value_valid  = out_q.value_valid;
  assign out_o.status_valid = out_q.status_valid;
  assign out_o.status       = out_q.status;
  assign out_o.tag_length   = out_q.tag_length;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_stream_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STREAM || phase_q == PH_SKIP) |-> (val_left_q != '0))
    else $error("value phase entered with no value bytes left");

  a_len_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN) |-> (len_left_q != '0))
    else $error("length phase entered with no length bytes left");

  a_last_rearms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last_byte) |=> (phase_q == PH_TAG && !is_match_q))
    else $error("parser not rearmed after the last byte of a record");

endmodule
